FILE: sv/acpu_pkg.sv
// Shared constants and types for the accumulator CPU.
`default_nettype none
package acpu_pkg;
  localparam int MEM_WORDS = 4096;
  localparam int WORD_BITS = 32;
  localparam int AW = $clog2(MEM_WORDS);
  localparam int PCW = 12;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_STOP  = 3'd1;
  localparam logic [2:0] ST_DIVZ  = 3'd2;
  localparam logic [2:0] ST_BADOP = 3'd3;
  localparam logic [2:0] ST_ADDR  = 3'd4;
  localparam logic [2:0] ST_IDLE  = 3'd5;

  localparam logic [3:0] OPC_ADD = 4'd1;
  localparam logic [3:0] OPC_SUB = 4'd2;
  localparam logic [3:0] OPC_MULT = 4'd3;
  localparam logic [3:0] OPC_DIV = 4'd4;
  localparam logic [3:0] OPC_JMP = 4'd5;
  localparam logic [3:0] OPC_JMPN = 4'd6;
  localparam logic [3:0] OPC_JMPP = 4'd7;
  localparam logic [3:0] OPC_JMPZ = 4'd8;
  localparam logic [3:0] OPC_COPY = 4'd9;
  localparam logic [3:0] OPC_LOAD = 4'd10;
  localparam logic [3:0] OPC_STORE = 4'd11;
  localparam logic [3:0] OPC_INPUT = 4'd12;
  localparam logic [3:0] OPC_OUTPUT = 4'd13;
  localparam logic [3:0] OPC_STOP = 4'd14;

  typedef logic [WORD_BITS-1:0] word_t;
endpackage
`default_nettype wire

FILE: sv/acpu_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module acpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: sv/acpu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module acpu_div (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  go,
  input  wire acpu_pkg::word_t dividend,
  input  wire acpu_pkg::word_t divisor,
  output logic       done,
  output acpu_pkg::word_t quotient
);
  import acpu_pkg::*;

  localparam int CW = $clog2(WORD_BITS + 1);
  logic [CW-1:0] cnt_r;
  logic          busy_r, neg_r;
  word_t         q_r, d_r;
  logic [WORD_BITS:0] rem_r;
  logic [WORD_BITS:0] trial;
  word_t ma, mb;

  assign ma = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
  assign mb = divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
  assign trial = {rem_r[WORD_BITS-1:0], q_r[WORD_BITS-1]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (go && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(WORD_BITS);
        q_r <= ma;
        d_r <= mb;
        rem_r <= '0;
        neg_r <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      end else if (busy_r) begin
        if (trial[WORD_BITS]) begin
          rem_r <= {rem_r[WORD_BITS-1:0], q_r[WORD_BITS-1]};
          q_r <= {q_r[WORD_BITS-2:0], 1'b0};
        end else begin
          rem_r <= trial;
          q_r <= {q_r[WORD_BITS-2:0], 1'b1};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg_r ? (~q_r + 1'b1) : q_r;
endmodule
`default_nettype wire

FILE: sv/accumulator_cpu_step.sv
// Top level: accumulator CPU sequencer around one word memory.
// Load, start and halted step go straight to DONE; step runs F0 to F2 (F3 for
// COPY), OPR, EXE and DIV for divide. Next request taken while the strobe is high.
// Memory cleared by a sweep over all 4096 words after reset, busy high meanwhile.
// Reset: synchronous, active low; ACC and PC zero, halted set, base zero.
// Results come as a one-cycle strobe; the receiver cannot stall.
`default_nettype none
module accumulator_cpu_step (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [11:0] in_word_index,
  input  wire logic [31:0] in_word_value,
  input  wire logic        in_relocate,
  input  wire logic [31:0] in_input_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_load_base,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [11:0]      out_pc_now,
  output logic [31:0]      out_acc_now,
  output logic [3:0]       out_executed_opcode,
  output logic             out_out_valid,
  output logic [31:0]      out_out_value,
  output logic             out_input_taken
);
  import acpu_pkg::*;

  // sequencer states
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_F0 = 4'd2, S_F1 = 4'd3,
                         S_F2 = 4'd4, S_F3 = 4'd5, S_OPR = 4'd6, S_EXE = 4'd7,
                         S_DIV = 4'd8, S_DONE = 4'd9;
  logic [3:0] st_r;

  logic [11:0] base_r;
  logic [AW:0] clr_r;
  logic [31:0] ival_r;
  word_t acc_r, code_r, a1_r, a2_r;
  // one extra bit: PC may step to one past the last word
  logic [PCW:0] pc_r;
  logic halted_r;

  // memory port
  logic mwe;
  logic [AW-1:0] maddr;
  word_t mwdata, mrdata;
  acpu_ram #(.WIDTH(WORD_BITS), .DEPTH(MEM_WORDS)) u_ram (
    .clk(clk), .we(mwe), .addr(maddr), .wdata(mwdata), .rdata(mrdata));

  // divider
  logic div_go, div_done;
  word_t div_q;
  acpu_div u_div (.clk(clk), .rst_n(rst_n), .go(div_go), .dividend(acc_r),
    .divisor(mrdata), .done(div_done), .quotient(div_q));

  assign busy = (st_r != S_IDLE);
  assign cfg_ready = (st_r == S_IDLE);

  logic [12:0] ld_addr;
  word_t ld_word;
  assign ld_addr = {1'b0, base_r} + {1'b0, in_word_index};
  assign ld_word = in_relocate ? (in_word_value + WORD_BITS'(base_r)) : in_word_value;

  function automatic logic addr_ok(word_t w);
    return (w[WORD_BITS-1] == 1'b0) && (w < WORD_BITS'(MEM_WORDS));
  endfunction

  logic [12:0] pc_p1, pc_p2;
  assign pc_p1 = pc_r + 13'd1;
  assign pc_p2 = pc_r + 13'd2;

  logic [3:0] opc;
  assign opc = code_r[3:0];
  logic is_copy;
  assign is_copy = (opc == OPC_COPY);

  always_comb begin
    mwe = 1'b0;
    maddr = pc_r[AW-1:0];
    mwdata = '0;
    div_go = 1'b0;
    unique case (st_r)
      S_CLR: begin
        mwe = 1'b1;
        maddr = clr_r[AW-1:0];
      end
      S_IDLE: begin
        if (start && in_op == OP_LOAD && !ld_addr[12]) begin
          mwe = 1'b1;
          maddr = ld_addr[AW-1:0];
          mwdata = ld_word;
        end else begin
          maddr = pc_r[AW-1:0];
        end
      end
      S_F1: maddr = pc_p1[AW-1:0];
      S_F2: maddr = pc_p2[AW-1:0];
      S_OPR: maddr = a1_r[AW-1:0];
      S_EXE: begin
        if (opc == OPC_COPY) begin
          mwe = 1'b1; maddr = a2_r[AW-1:0]; mwdata = mrdata;
        end else if (opc == OPC_STORE) begin
          mwe = 1'b1; maddr = a1_r[AW-1:0]; mwdata = acc_r;
        end else if (opc == OPC_INPUT) begin
          mwe = 1'b1; maddr = a1_r[AW-1:0]; mwdata = ival_r;
        end
        div_go = (opc == OPC_DIV) && (mrdata != '0);
      end
      default: ;
    endcase
  end

  logic [31:0] prod;
  assign prod = acc_r * mrdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      base_r <= '0;
      acc_r <= '0;
      pc_r <= '0;
      halted_r <= 1'b1;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_load_base;
      end
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(MEM_WORDS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            ival_r <= in_input_value;
            out_status <= ST_OK;
            out_executed_opcode <= '0;
            out_out_valid <= 1'b0;
            out_out_value <= '0;
            out_input_taken <= 1'b0;
            if (in_op == OP_LOAD) begin
              if (ld_addr[12]) out_status <= ST_ADDR;
              st_r <= S_DONE;
            end else if (in_op == OP_START) begin
              pc_r <= {1'b0, base_r};
              acc_r <= '0;
              halted_r <= 1'b0;
              st_r <= S_DONE;
            end else if (in_op == OP_STEP) begin
              if (halted_r) begin
                out_status <= ST_IDLE;
                st_r <= S_DONE;
              end else if (pc_r[PCW]) begin
                // PC ran off the end of memory: fetch address error
                out_status <= ST_ADDR; halted_r <= 1'b1; st_r <= S_DONE;
              end else begin
                st_r <= S_F0;
              end
            end else begin
              st_r <= S_DONE;
            end
          end
        end
        S_F0: begin
          code_r <= mrdata;
          if (mrdata == '0 || mrdata > WORD_BITS'(14)) begin
            out_status <= ST_BADOP; halted_r <= 1'b1; st_r <= S_DONE;
          end else begin
            out_executed_opcode <= mrdata[3:0];
            if (mrdata[3:0] == OPC_STOP) begin
              out_status <= ST_STOP; halted_r <= 1'b1; st_r <= S_DONE;
            end else if (pc_p1[12] ||
                         (mrdata[3:0] == OPC_COPY && pc_p2[12])) begin
              out_status <= ST_ADDR; halted_r <= 1'b1; st_r <= S_DONE;
            end else begin
              st_r <= S_F1;
            end
          end
        end
        S_F1: st_r <= S_F2;
        S_F2: begin
          a1_r <= mrdata;
          if (!addr_ok(mrdata)) begin
            out_status <= ST_ADDR; halted_r <= 1'b1; st_r <= S_DONE;
          end else if (is_copy) begin
            st_r <= S_F3;
          end else begin
            st_r <= S_OPR;
          end
        end
        S_F3: begin
          a2_r <= mrdata;
          if (!addr_ok(mrdata)) begin
            out_status <= ST_ADDR; halted_r <= 1'b1; st_r <= S_DONE;
          end else begin
            st_r <= S_OPR;
          end
        end
        S_OPR: st_r <= S_EXE;
        S_EXE: begin
          st_r <= S_DONE;
          pc_r <= is_copy ? pc_r + 13'd3 : pc_p2;
          case (opc)
            OPC_ADD: acc_r <= acc_r + mrdata;
            OPC_SUB: acc_r <= acc_r - mrdata;
            OPC_MULT: acc_r <= prod;
            OPC_DIV: begin
              if (mrdata == '0) begin
                out_status <= ST_DIVZ; halted_r <= 1'b1; pc_r <= pc_r;
              end else begin
                st_r <= S_DIV;
              end
            end
            OPC_JMP: pc_r <= {1'b0, a1_r[PCW-1:0]};
            OPC_JMPN: if (acc_r[31]) pc_r <= {1'b0, a1_r[PCW-1:0]};
            OPC_JMPP: if (!acc_r[31] && acc_r != '0) pc_r <= {1'b0, a1_r[PCW-1:0]};
            OPC_JMPZ: if (acc_r == '0) pc_r <= {1'b0, a1_r[PCW-1:0]};
            OPC_LOAD: acc_r <= mrdata;
            OPC_INPUT: out_input_taken <= 1'b1;
            OPC_OUTPUT: begin
              out_out_valid <= 1'b1; out_out_value <= mrdata;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            acc_r <= div_q; st_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_strobe <= 1'b1;
          out_pc_now <= pc_r[PCW-1:0];
          out_acc_now <= acc_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // result strobe only after a sequence finishes
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(st_r) == S_DONE) else $error("stray strobe");
  // no memory write while waiting on the divider
  a_divwr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |-> !mwe) else $error("write during divide");
  // a request taken while idle raises busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && start) |=> busy) else $error("busy not raised");
endmodule
`default_nettype wire
